>>> rtl/pgwalk_pkg.sv
`timescale 1ns / 1ps

package pgwalk_pkg;

  // table geometry
  localparam int unsigned FRAMES_DEFAULT    = 32;
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;

  // field widths
  localparam int unsigned ROOT_W   = 5;
  localparam int unsigned WIDX_W   = 14;
  localparam int unsigned WORD_W   = 64;
  localparam int unsigned VA_W     = 48;
  localparam int unsigned PA_W     = 52;
  localparam int unsigned FRAME_W  = 40;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SIZE_W   = 2;

  // configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_ROOT_FRAME = 3'd0;

  // entry bits
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_SIZE    = 7;

  // item modes
  localparam logic MODE_WRITE     = 1'b0;
  localparam logic MODE_TRANSLATE = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_WRITE_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MAPPED     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_MAPPED = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FRAME_OOR  = 2'd3;

  // page size codes
  localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_4K   = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_2M   = 2'd2;
  localparam logic [SIZE_W-1:0] SIZE_1G   = 2'd3;

  // walk levels, top table first
  typedef enum logic [1:0] {
    STEP_PML4 = 2'd0,
    STEP_PDPT = 2'd1,
    STEP_PD   = 2'd2,
    STEP_PT   = 2'd3
  } step_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_t;

  function automatic logic [IDX_W-1:0] walk_index(input logic [VA_W-1:0] va,
                                                  input step_t step);
    logic [IDX_W-1:0] idx;
    unique case (step)
      STEP_PML4: idx = va[47:39];
      STEP_PDPT: idx = va[38:30];
      STEP_PD:   idx = va[29:21];
      STEP_PT:   idx = va[20:12];
      default:   idx = '0;
    endcase
    return idx;
  endfunction

endpackage

>>> rtl/pgwalk_ram.sv
`timescale 1ns / 1ps

module pgwalk_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/four_level_page_table_walker.sv
`timescale 1ns / 1ps
// channel  direction  handshake          word
// in       to block   in_valid/in_ready  mode, word_index, word_data, vaddr
// out      from block out_valid/out_ready status, physical_address, page_size_code, table_frame
// cfg      to block   apb psel/penable   root_frame at byte address 0
//
// a write word needs no table read; a translation makes 1 to 4 dependent table reads, one per
// cycle on the registered read port of the table ram, or none when the root frame lies
// past the tables
// reset starts a clearing pass over all FRAMES*512 table words (16384 at default); no word is
// taken during it, configuration writes still are
// a result that finds the output register full waits in a hold register and blocks the
// input; a new word is taken while a finished result still sits in the output register

module four_level_page_table_walker #(
  parameter int unsigned FRAMES = pgwalk_pkg::FRAMES_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pgwalk_pkg::PADDR_W-1:0]     paddr,
  input  logic [pgwalk_pkg::PDATA_W-1:0]     pwdata,
  output logic [pgwalk_pkg::PDATA_W-1:0]     prdata,
  output logic                               pready,
  // input words
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               mode,
  input  logic [pgwalk_pkg::WIDX_W-1:0]      word_index,
  input  logic [pgwalk_pkg::WORD_W-1:0]      word_data,
  input  logic [pgwalk_pkg::VA_W-1:0]        vaddr,
  // result words
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [pgwalk_pkg::STATUS_W-1:0]    status,
  output logic [pgwalk_pkg::PA_W-1:0]        physical_address,
  output logic [pgwalk_pkg::SIZE_W-1:0]      page_size_code,
  output logic [pgwalk_pkg::FRAME_W-1:0]     table_frame
);

  import pgwalk_pkg::*;

  localparam int unsigned DEPTH = FRAMES * ENTRIES_PER_TABLE;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned FW    = $clog2(FRAMES);

  // configuration register
  logic [ROOT_W-1:0] root_frame;
  logic              cfg_write;

  assign pready    = 1'b1;
  // byte offset bits are ignored, bit 2 picks the register
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[PADDR_W-1:2] == REG_ROOT_FRAME[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame <= '0;
    end else if (cfg_write) begin
      root_frame <= pwdata[ROOT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_ROOT_FRAME[PADDR_W-1:2]) begin
      prdata = PDATA_W'(root_frame);
    end
  end

  // control state
  state_t            state, state_next;
  step_t             step, step_next;
  logic [AW-1:0]     clr_cnt;
  logic [VA_W-1:0]   va, va_next;
  logic [FRAME_W-1:0] tframe, tframe_next;

  // table ram
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] entry;
  logic [FW-1:0]     rd_frame;
  logic [IDX_W-1:0]  rd_idx;

  pgwalk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (entry)
  );

  assign ram_raddr = AW'({rd_frame, rd_idx});

  // handshakes
  logic in_fire;
  logic slot_free;
  logic write_in_range;

  assign in_ready       = (state == ST_IDLE);
  assign in_fire        = in_valid && in_ready;
  assign slot_free      = !out_valid || out_ready;
  // words beyond the table are dropped but still answered
  assign write_in_range = (32'(word_index) < DEPTH);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(word_index);
    ram_wdata = word_data;
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else if (in_fire && (mode == MODE_WRITE) && write_in_range) begin
      ram_we = 1'b1;
    end
  end

  // decoded table entry
  logic               e_present;
  logic               e_size;
  logic [FRAME_W-1:0] e_frame;
  logic               e_frame_ok;

  assign e_present  = entry[BIT_PRESENT];
  assign e_size     = entry[BIT_SIZE];
  assign e_frame    = entry[51:12];
  assign e_frame_ok = (e_frame < FRAME_W'(FRAMES));

  // finished result of this cycle
  logic                fin_valid;
  logic [STATUS_W-1:0] fin_status;
  logic [PA_W-1:0]     fin_pa;
  logic [SIZE_W-1:0]   fin_code;
  logic [FRAME_W-1:0]  fin_tframe;

  // hold register for a result that finds the output full
  logic [STATUS_W-1:0] res_status;
  logic [PA_W-1:0]     res_pa;
  logic [SIZE_W-1:0]   res_code;
  logic [FRAME_W-1:0]  res_tframe;
  logic                res_load;

  logic                out_load;
  logic [STATUS_W-1:0] out_status_next;
  logic [PA_W-1:0]     out_pa_next;
  logic [SIZE_W-1:0]   out_code_next;
  logic [FRAME_W-1:0]  out_tframe_next;

  always_comb begin
    state_next  = state;
    step_next   = step;
    va_next     = va;
    tframe_next = tframe;
    ram_re      = 1'b0;
    rd_frame    = FW'(root_frame);
    rd_idx      = walk_index(vaddr, STEP_PML4);
    fin_valid   = 1'b0;
    fin_status  = STATUS_NOT_MAPPED;
    fin_pa      = '0;
    fin_code    = SIZE_NONE;
    fin_tframe  = '0;

    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (mode == MODE_WRITE) begin
            fin_valid  = 1'b1;
            fin_status = STATUS_WRITE_DONE;
          end else begin
            va_next = vaddr;
            if (32'(root_frame) < FRAMES) begin
              // first read goes out with the accepting edge
              ram_re     = 1'b1;
              step_next  = STEP_PML4;
              state_next = ST_WALK;
            end else begin
              fin_valid  = 1'b1;
              fin_status = STATUS_FRAME_OOR;
            end
          end
        end
      end
      ST_WALK: begin
        rd_frame = e_frame[FW-1:0];
        rd_idx   = walk_index(va, step_t'(step + 2'd1));
        unique case (step)
          STEP_PML4: begin
            if (!e_present) begin
              fin_valid = 1'b1;
            end else if (!e_frame_ok) begin
              fin_valid  = 1'b1;
              fin_status = STATUS_FRAME_OOR;
            end else begin
              ram_re    = 1'b1;
              step_next = STEP_PDPT;
            end
          end
          STEP_PDPT: begin
            if (!e_present) begin
              fin_valid = 1'b1;
            end else if (e_size) begin
              // 1 GiB page
              fin_valid  = 1'b1;
              fin_status = STATUS_MAPPED;
              fin_code   = SIZE_1G;
              fin_pa     = {entry[51:30], va[29:0]};
            end else if (!e_frame_ok) begin
              fin_valid  = 1'b1;
              fin_status = STATUS_FRAME_OOR;
            end else begin
              ram_re    = 1'b1;
              step_next = STEP_PD;
            end
          end
          STEP_PD: begin
            if (!e_present) begin
              fin_valid = 1'b1;
            end else if (e_size) begin
              // 2 MiB page
              fin_valid  = 1'b1;
              fin_status = STATUS_MAPPED;
              fin_code   = SIZE_2M;
              fin_pa     = {entry[51:21], va[20:0]};
            end else if (!e_frame_ok) begin
              fin_valid  = 1'b1;
              fin_status = STATUS_FRAME_OOR;
            end else begin
              ram_re      = 1'b1;
              step_next   = STEP_PT;
              tframe_next = e_frame;
            end
          end
          STEP_PT: begin
            // leaf frame names data memory, no range check
            fin_valid  = 1'b1;
            fin_tframe = tframe;
            if (e_present) begin
              fin_status = STATUS_MAPPED;
              fin_code   = SIZE_4K;
              fin_pa     = {entry[51:12], va[11:0]};
            end
          end
          default: begin
            fin_valid = 1'b0;
          end
        endcase
      end
      ST_HOLD: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // route a finished result to the output or the hold register
    res_load        = 1'b0;
    out_load        = 1'b0;
    out_status_next = fin_status;
    out_pa_next     = fin_pa;
    out_code_next   = fin_code;
    out_tframe_next = fin_tframe;
    if (fin_valid) begin
      if (slot_free) begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end else begin
        res_load   = 1'b1;
        state_next = ST_HOLD;
      end
    end else if ((state == ST_HOLD) && slot_free) begin
      out_load        = 1'b1;
      out_status_next = res_status;
      out_pa_next     = res_pa;
      out_code_next   = res_code;
      out_tframe_next = res_tframe;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      step      <= STEP_PML4;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    va     <= va_next;
    tframe <= tframe_next;
    if (res_load) begin
      res_status <= fin_status;
      res_pa     <= fin_pa;
      res_code   <= fin_code;
      res_tframe <= fin_tframe;
    end
    if (out_load) begin
      status           <= out_status_next;
      physical_address <= out_pa_next;
      page_size_code   <= out_code_next;
      table_frame      <= out_tframe_next;
    end
  end

endmodule

>>> verif/four_level_page_table_walker_tb.sv
`timescale 1ns / 1ps

module four_level_page_table_walker_tb;
  import pgwalk_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned TABLE_WORDS  = FRAMES_DEFAULT * ENTRIES_PER_TABLE;
  localparam int unsigned TOTAL_WORDS  = 1650;
  localparam int unsigned PHASES       = 6;
  // receiver goes quiet for a long stretch once this many words went in
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 400;
  // quiet cycles allowed: covers the clearing pass after reset and the long hold
  localparam int unsigned STALL_LIMIT  = 50000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef struct packed {
    logic               mode;
    logic [WIDX_W-1:0]  word_index;
    logic [WORD_W-1:0]  word_data;
    logic [VA_W-1:0]    vaddr;
  } walk_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     physical_address;
    logic [SIZE_W-1:0]   page_size_code;
    logic [FRAME_W-1:0]  table_frame;
  } walk_result_t;

  // shadow of the table memory and root register, plus the results still owed
  class walk_scoreboard;
    logic [WORD_W-1:0] table_mem [TABLE_WORDS];
    logic [ROOT_W-1:0] root_frame;
    walk_result_t      expected_q[$];
    int unsigned       words_in;
    int unsigned       errors;

    function new();
      foreach (table_mem[i]) table_mem[i] = '0;
      root_frame = '0;
      words_in   = 0;
      errors     = 0;
    endfunction

    // apply one accepted word to the shadow state and queue its result
    function void note_word(walk_word_t w);
      walk_result_t       r;
      logic [WORD_W-1:0]  e;
      logic [FRAME_W-1:0] fr;
      logic [IDX_W-1:0]   idx;
      int                 lvl;
      bit                 done;
      r = '0;
      words_in++;
      if (w.mode == MODE_WRITE) begin
        if (w.word_index < TABLE_WORDS) table_mem[w.word_index] = w.word_data;
        r.status = STATUS_WRITE_DONE;
      end else begin
        r.status = STATUS_NOT_MAPPED;
        fr       = FRAME_W'(root_frame);
        done     = 1'b0;
        // lvl 0 is the top table, lvl 3 the page table
        for (lvl = 0; lvl < 4 && !done; lvl++) begin
          idx = w.vaddr[47 - 9*lvl -: 9];
          if (fr >= FRAMES_DEFAULT) begin
            // a table frame past the memory ends the walk, other fields stay 0
            r.status = STATUS_FRAME_OOR;
            done     = 1'b1;
          end else begin
            if (lvl == 3) r.table_frame = fr;
            e = table_mem[fr * ENTRIES_PER_TABLE + idx];
            if (!e[BIT_PRESENT]) begin
              done = 1'b1;
            end else if (lvl == 1 && e[BIT_SIZE]) begin
              r.status           = STATUS_MAPPED;
              r.page_size_code   = SIZE_1G;
              r.physical_address = {e[51:30], w.vaddr[29:0]};
              done               = 1'b1;
            end else if (lvl == 2 && e[BIT_SIZE]) begin
              r.status           = STATUS_MAPPED;
              r.page_size_code   = SIZE_2M;
              r.physical_address = {e[51:21], w.vaddr[20:0]};
              done               = 1'b1;
            end else if (lvl == 3) begin
              // leaf frame names data memory, so no range check here
              r.status           = STATUS_MAPPED;
              r.page_size_code   = SIZE_4K;
              r.physical_address = {e[51:12], w.vaddr[11:0]};
              done               = 1'b1;
            end else begin
              fr = e[51:12];
            end
          end
        end
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(walk_result_t got);
      walk_result_t want;
      if (expected_q.size() == 0) begin
        $error("result word with none expected: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.physical_address !== want.physical_address) begin
        $error("physical_address: expected %h, got %h",
               want.physical_address, got.physical_address);
        errors++;
      end
      if (got.page_size_code !== want.page_size_code) begin
        $error("page_size_code: expected %0d, got %0d",
               want.page_size_code, got.page_size_code);
        errors++;
      end
      if (got.table_frame !== want.table_frame) begin
        $error("table_frame: expected %h, got %h", want.table_frame, got.table_frame);
        errors++;
      end
    endfunction
  endclass

  logic                clk             = 1'b0;
  logic                rst             = 1'b1;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [PDATA_W-1:0]  pwdata          = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic                mode            = MODE_WRITE;
  logic [WIDX_W-1:0]   word_index      = '0;
  logic [WORD_W-1:0]   word_data       = '0;
  logic [VA_W-1:0]     vaddr           = '0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [PA_W-1:0]     physical_address;
  logic [SIZE_W-1:0]   page_size_code;
  logic [FRAME_W-1:0]  table_frame;

  walk_scoreboard walk_sb;
  // random gaps on both sides; switched off for the last phase
  bit             idle_on = 1'b1;

  four_level_page_table_walker u_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .mode             (mode),
    .word_index       (word_index),
    .word_data        (word_data),
    .vaddr            (vaddr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .physical_address (physical_address),
    .page_size_code   (page_size_code),
    .table_frame      (table_frame)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // table entry with random filler in the bits the walk must ignore
  function automatic logic [WORD_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                   input bit present, input bit huge);
    logic [WORD_W-1:0] e;
    e              = rand64();
    e[51:12]       = frame;
    e[BIT_SIZE]    = huge;
    e[BIT_PRESENT] = present;
    return e;
  endfunction

  // offer one word, maybe after a gap; valid stays up for a following word
  task automatic send_word(input logic m, input logic [WIDX_W-1:0] widx,
                           input logic [WORD_W-1:0] data, input logic [VA_W-1:0] va);
    int         gap;
    walk_word_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    w.mode       = m;
    w.word_index = widx;
    w.word_data  = data;
    w.vaddr      = va;
    in_valid   <= 1'b1;
    mode       <= m;
    word_index <= widx;
    word_data  <= data;
    vaddr      <= va;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_sb.note_word(w);
  endtask

  // unused fields carry noise so the block is seen to ignore them
  task automatic write_entry(input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] data);
    send_word(MODE_WRITE, widx, data, VA_W'(rand64()));
  endtask

  task automatic translate(input logic [VA_W-1:0] va);
    send_word(MODE_TRANSLATE, WIDX_W'($urandom), rand64(), va);
  endtask

  // root register write, only with nothing in flight
  task automatic set_root(input logic [ROOT_W-1:0] r);
    logic [PDATA_W-1:0] data;
    in_valid <= 1'b0;
    while (walk_sb.expected_q.size() != 0) @(posedge clk);
    data              = $urandom;
    data[ROOT_W-1:0]  = r;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ROOT_FRAME;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    walk_sb.root_frame = r;
  endtask

  // build a walk path for a random address, top table first, then probe it
  task automatic walk_sequence();
    logic [VA_W-1:0]    va;
    logic [VA_W-1:0]    probe;
    logic [ROOT_W-1:0]  f3;
    logic [ROOT_W-1:0]  f2;
    logic [ROOT_W-1:0]  f1;
    logic [FRAME_W-1:0] far;
    logic [WORD_W-1:0]  broken;
    int                 kind;
    int                 break_lvl;
    int                 probes;
    int                 k;
    va        = VA_W'(rand64());
    f3        = ROOT_W'($urandom_range(0, FRAMES_DEFAULT - 1));
    f2        = ROOT_W'($urandom_range(0, FRAMES_DEFAULT - 1));
    f1        = ROOT_W'($urandom_range(0, FRAMES_DEFAULT - 1));
    // leaf kind: 0..1 1 gib page, 2..3 2 mib page, rest 4 kib page
    kind      = $urandom_range(0, 9);
    // most paths are whole; some break at a random level
    break_lvl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 4;
    far       = FRAME_W'(rand64());
    if (far < FRAMES_DEFAULT) far[FRAME_W-1] = 1'b1;
    // a broken link is either absent or points past the table memory
    broken = $urandom_range(0, 1) ? make_entry(far, 1'b1, 1'b0)
                                  : make_entry(FRAME_W'(rand64()), 1'b0,
                                               1'($urandom_range(0, 1)));
    // top level ignores the size bit, so it is random there
    write_entry({walk_sb.root_frame, va[47:39]},
                break_lvl == 0 ? broken
                               : make_entry(FRAME_W'(f3), 1'b1, 1'($urandom_range(0, 1))));
    if (break_lvl > 0) begin
      if (break_lvl == 1) begin
        write_entry({f3, va[38:30]}, broken);
      end else if (kind < 2) begin
        write_entry({f3, va[38:30]}, make_entry(FRAME_W'(rand64()), 1'b1, 1'b1));
      end else begin
        write_entry({f3, va[38:30]}, make_entry(FRAME_W'(f2), 1'b1, 1'b0));
        if (break_lvl == 2) begin
          write_entry({f2, va[29:21]}, broken);
        end else if (kind < 4) begin
          write_entry({f2, va[29:21]}, make_entry(FRAME_W'(rand64()), 1'b1, 1'b1));
        end else begin
          write_entry({f2, va[29:21]}, make_entry(FRAME_W'(f1), 1'b1, 1'b0));
          // page table level also ignores the size bit
          write_entry({f1, va[20:12]}, break_lvl == 3 ? broken
                      : make_entry(FRAME_W'(rand64()), 1'b1, 1'($urandom_range(0, 1))));
        end
      end
    end
    translate(va);
    probes = $urandom_range(0, 3);
    for (k = 0; k < probes; k++) begin
      probe = va;
      case ($urandom_range(0, 2))
        0: probe[11:0] = 12'($urandom);
        1: probe[29:0] = 30'($urandom);
        default: probe[20:12] = 9'($urandom);
      endcase
      translate(probe);
    end
  endtask

  // stimulus
  initial begin
    logic [VA_W-1:0] va_a;
    int unsigned     goal;
    int              p;
    walk_sb = new();
    va_a    = {9'd1, 9'd2, 9'd3, 9'd4, 12'habc};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // empty tables under the reset root
    translate('0);
    translate('1);
    set_root(ROOT_W'(FRAMES_DEFAULT - 1));
    // top entry with the size bit set, which the top level ignores
    write_entry({5'd31, 9'd1}, make_entry(40'd7, 1'b1, 1'b1));
    // 1 gib page, low frame bits must not reach the address
    write_entry({5'd7, 9'd2}, make_entry('1, 1'b1, 1'b1));
    translate(va_a);
    write_entry({5'd7, 9'd2}, make_entry(40'd9, 1'b1, 1'b0));
    // 2 mib page
    write_entry({5'd9, 9'd3}, make_entry('1, 1'b1, 1'b1));
    translate(va_a);
    // page table reached but entry absent
    write_entry({5'd9, 9'd3}, make_entry(40'd11, 1'b1, 1'b0));
    translate(va_a);
    // 4 kib leaf whose frame lies far past the table memory
    write_entry({5'd11, 9'd4}, make_entry('1, 1'b1, 1'b1));
    translate(va_a);
    translate({va_a[47:12], 12'hfff});
    // absent entry with the size bit set
    write_entry({5'd7, 9'd2}, make_entry(40'd9, 1'b0, 1'b1));
    translate(va_a);
    // first frame past the tables, as a directory pointer
    write_entry({5'd7, 9'd2}, make_entry(40'd32, 1'b1, 1'b0));
    translate(va_a);
    // page directory pointing past the tables
    write_entry({5'd7, 9'd2}, make_entry(40'd9, 1'b1, 1'b0));
    write_entry({5'd9, 9'd3}, make_entry('1, 1'b1, 1'b0));
    translate(va_a);
    // last word of memory is the last root entry; all bits set
    write_entry('1, '1);
    translate('1);
    write_entry('0, '0);
    translate('0);

    // random phases, each under its own root; extremes first and last
    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 1) idle_on <= 1'b0;
      set_root(p == 0 ? ROOT_W'(0) : p == PHASES - 1 ? ROOT_W'(FRAMES_DEFAULT - 1)
                                                     : ROOT_W'($urandom));
      goal = (p + 1) * TOTAL_WORDS / PHASES;
      while (walk_sb.words_in < goal) begin
        case ($urandom_range(0, 9))
          0: write_entry(WIDX_W'($urandom_range(0, TABLE_WORDS - 1)), rand64());
          1: translate(VA_W'(rand64()));
          default: walk_sequence();
        endcase
      end
    end

    in_valid <= 1'b0;
    while (walk_sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (walk_sb.errors == 0 && walk_sb.expected_q.size() == 0)
      $display("** four_level_page_table_walker: PASSED **");
    else
      $display("** four_level_page_table_walker: FAILED **");
    $finish;
  end

  // result side: check every accepted word, stall in random bursts
  initial begin
    int           stall_left;
    bit           held;
    walk_result_t got;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.status           = status;
        got.physical_address = physical_address;
        got.page_size_code   = page_size_code;
        got.table_frame      = table_frame;
        walk_sb.check_result(got);
      end
      // one long hold so the block backs up into its input
      if (!held && walk_sb.words_in >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 13);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("** four_level_page_table_walker: FAILED **");
    $finish;
  end

endmodule
